// ===== design/fcmc_pkg.sv =====
// shared constants and types for the fifo replacement cache miss counter
package fcmc_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W     = 7;
  localparam int MISS_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  // register select bit of the byte address
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic shift;  // miss: every cell takes its neighbor's entry
    logic evict;  // oldest entry leaves, occupancy holds
  } fcmc_ctrl_t;

endpackage

// ===== design/fifo_cache_miss_counter.sv =====
// top level of the fifo replacement cache miss counter
//
// fully associative cache with first-in-first-out replacement, built as a
// chain of cells: cell 0 holds the newest entry, the valid run ends at the
// oldest one. every cell compares its entry against the incoming word
//
// input channel: a beat is taken at the rising edge where start is high and
// busy is low. busy stays low, so a word can come in every cycle
// result channel: one result per beat, shown for exactly one cycle with
// valid_o high, on the cycle right after the beat was taken (throughput 1
// word per cycle, as the whole chain compares and shifts at once on each
// taken beat). the receiver cannot stall; results are never held
// miss_total_o shows the saturating miss count including the current beat
//
// config: apb-style port, capacity at byte address 0; the user must write it
// only while the block is idle (not enforced by the block). capacity 0 acts as 1,
// above the chain depth as the depth. lowering it below the fill evicts one entry per miss
//
// reset clears all valid flags, the miss count, and sets capacity to 64;
// no clearing pass is needed
module fifo_cache_miss_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [fcmc_pkg::WORD_BITS-1:0] word_i,
  input  logic                           last_word_i,
  // result channel
  output logic                           valid_o,
  output logic                           hit_o,
  output logic                           evicted_valid_o,
  output logic [fcmc_pkg::WORD_BITS-1:0] evicted_word_o,
  output logic [fcmc_pkg::MISS_W-1:0]    miss_total_o,
  output logic                           final_res_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fcmc_pkg::ADDR_W-1:0]    paddr,
  input  logic [fcmc_pkg::DATA_W-1:0]    pwdata,
  output logic [fcmc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import fcmc_pkg::*;

  // capacity register
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  logic [IDX_W-1:0] cap_idx;   // effective capacity minus one

  // chain wiring
  logic [WORD_BITS-1:0] cell_word   [DEPTH];
  logic [WORD_BITS-1:0] cell_oldest [DEPTH];
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     cell_match;
  fcmc_ctrl_t           ctrl;

  logic                 accept;
  logic                 hit;
  logic                 full;
  logic [WORD_BITS-1:0] oldest_word;
  logic [MISS_W-1:0]    miss_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // ---------------- configuration ----------------
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_q) : '0;

  // clamp capacity to 1..DEPTH and turn it into a cell index
  always_comb begin
    if (cap_q == '0) begin
      cap_idx = '0;
    end else if (32'(cap_q) > DEPTH) begin
      cap_idx = IDX_W'(DEPTH - 1);
    end else begin
      cap_idx = IDX_W'(cap_q - CAP_W'(1));
    end
  end

  // ---------------- cell chain ----------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_BITS-1:0] prev_word;
    logic                 prev_valid;
    logic                 next_valid;

    if (k == 0) begin : g_head
      // the new word enters at the head as the newest entry
      assign prev_word  = word_i;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_word  = cell_word[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_valid = cell_valid[k+1];
    end

    fcmc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (word_i),
      .prev_word_i   (prev_word),
      .prev_valid_i  (prev_valid),
      .next_valid_i  (next_valid),
      .word_o        (cell_word[k]),
      .valid_o       (cell_valid[k]),
      .match_o       (cell_match[k]),
      .oldest_word_o (cell_oldest[k])
    );
  end

  // at most one cell flags itself oldest, so an or gathers its entry
  always_comb begin
    oldest_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      oldest_word = oldest_word | cell_oldest[k];
    end
  end

  assign hit  = |cell_match;
  // occupancy reached capacity when the cell at capacity-1 is in use
  assign full = cell_valid[cap_idx];

  assign ctrl = '{shift: accept && !hit, evict: accept && !hit && full};

  // ---------------- miss count ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q <= '0;
    end else if (ctrl.shift && (miss_q != '1)) begin
      miss_q <= miss_q + MISS_W'(1);
    end
  end

  assign miss_total_o = miss_q;

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_o           <= hit;
      evicted_valid_o <= ctrl.evict;
      evicted_word_o  <= ctrl.evict ? oldest_word : '0;
      final_res_o     <= last_word_i;
    end
  end

endmodule

// ===== design/fcmc_cell.sv =====
// one storage cell of the cache chain: entry, valid flag, compare
module fcmc_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcmc_pkg::fcmc_ctrl_t          ctrl_i,
  input  logic [fcmc_pkg::WORD_BITS-1:0] key_i,
  input  logic [fcmc_pkg::WORD_BITS-1:0] prev_word_i,
  input  logic                          prev_valid_i,
  input  logic                          next_valid_i,
  output logic [fcmc_pkg::WORD_BITS-1:0] word_o,
  output logic                          valid_o,
  output logic                          match_o,
  output logic [fcmc_pkg::WORD_BITS-1:0] oldest_word_o
);
  import fcmc_pkg::*;

  logic [WORD_BITS-1:0] word_q;
  logic                 valid_q;
  logic                 oldest;

  // oldest entry sits at the end of the valid run
  assign oldest        = valid_q && !next_valid_i;
  assign match_o       = valid_q && (word_q == key_i);
  assign oldest_word_o = oldest ? word_q : '0;
  assign word_o        = word_q;
  assign valid_o       = valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      word_q <= prev_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift && !ctrl_i.evict) begin
      valid_q <= prev_valid_i;
    end
  end

endmodule

// ===== design/fcmc_checker.sv =====
// port-level checks for the fifo replacement cache miss counter
module fcmc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           valid_o,
  input logic                           hit_o,
  input logic                           evicted_valid_o,
  input logic [fcmc_pkg::WORD_BITS-1:0] evicted_word_o,
  input logic [fcmc_pkg::MISS_W-1:0]    miss_total_o
);
  import fcmc_pkg::*;

  // one result follows every taken beat, and nothing else
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> valid_o)
    else $error("taken beat gave no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !valid_o)
    else $error("result without a taken beat");

  // a hit never evicts, and a missing eviction shows a zero word
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (!(hit_o && evicted_valid_o) && (evicted_valid_o || evicted_word_o == '0)))
    else $error("eviction fields inconsistent");

  // count steps by one on a miss between back-to-back results
  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(valid_o) && !hit_o && ($past(miss_total_o) != '1))
      |-> (miss_total_o == $past(miss_total_o) + MISS_W'(1)))
    else $error("miss count did not advance");

  a_hit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(valid_o) && hit_o) |-> $stable(miss_total_o))
    else $error("miss count moved on a hit");

endmodule

bind fifo_cache_miss_counter fcmc_checker u_fcmc_checker (.*);

// ===== verif/fifo_cache_miss_counter_tb.sv =====
// self-checking testbench for the fifo replacement cache miss counter
module fifo_cache_miss_counter_tb;
  import fcmc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // byte addresses on the config port: capacity, and one that maps to no register
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] UNUSED_ADDR   = ADDR_W'(4);

  localparam int DRAIN_LIMIT   = 2000;  // cycles allowed for results to come back
  localparam int SETTLE_CYCLES = 4;     // extra cycles waited after the drain

  // one expected result beat
  typedef struct {
    logic                 hit;
    logic                 evicted_valid;
    logic [WORD_BITS-1:0] evicted_word;
    logic [MISS_W-1:0]    miss_total;
    logic                 final_res;
  } lookup_outcome_t;

  // tracks cache contents and the miss count, and holds the outcomes still owed
  class cache_tracker;
    logic [WORD_BITS-1:0] ring_words [DEPTH];
    int unsigned          fill;
    int unsigned          head;
    logic [MISS_W-1:0]    misses;
    logic [CAP_W-1:0]     capacity;
    lookup_outcome_t      owed [$];
    int unsigned          mismatches;
    int unsigned          beats_in;
    int unsigned          beats_out;
    int unsigned          hits_seen;
    int unsigned          evictions_seen;

    function new();
      fill = 0;
      head = 0;
      misses = '0;
      capacity = CAP_RESET;
      mismatches = 0;
      beats_in = 0;
      beats_out = 0;
      hits_seen = 0;
      evictions_seen = 0;
    endfunction

    function void set_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
      if (addr == CAPACITY_ADDR) begin
        capacity = value[CAP_W-1:0];
      end
    endfunction

    function int unsigned usable_entries();
      int unsigned c;
      c = capacity;
      if (c == 0) begin
        c = 1;
      end
      if (c > DEPTH) begin
        c = DEPTH;
      end
      return c;
    endfunction

    // lookup and fifo update for one accepted beat
    function void note_lookup(logic [WORD_BITS-1:0] w, logic last);
      lookup_outcome_t o;
      o.hit = 1'b0;
      o.evicted_valid = 1'b0;
      o.evicted_word = '0;
      o.final_res = last;
      for (int unsigned i = 0; i < fill; i++) begin
        if (ring_words[(head + i) % DEPTH] == w) begin
          o.hit = 1'b1;
        end
      end
      if (!o.hit) begin
        if (misses != '1) begin
          misses = misses + 1'b1;
        end
        // only the single oldest entry leaves, even if fill exceeds the capacity
        if (fill >= usable_entries() && fill > 0) begin
          o.evicted_valid = 1'b1;
          o.evicted_word = ring_words[head];
          head = (head + 1) % DEPTH;
          fill--;
        end
        ring_words[(head + fill) % DEPTH] = w;
        fill++;
      end
      o.miss_total = misses;
      owed = {owed, o};
      beats_in++;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches++;
    endtask

    task check_outcome(lookup_outcome_t got);
      lookup_outcome_t want;
      beats_out++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing outstanding", beats_out));
      end else begin
        want = owed[0];
        owed.delete(0);
        if (got.hit !== want.hit)
          report_mismatch($sformatf("beat %0d hit %b, want %b", beats_out, got.hit, want.hit));
        if (got.evicted_valid !== want.evicted_valid)
          report_mismatch($sformatf("beat %0d evicted_valid %b, want %b", beats_out,
                                    got.evicted_valid, want.evicted_valid));
        if (got.evicted_word !== want.evicted_word)
          report_mismatch($sformatf("beat %0d evicted_word %h, want %h", beats_out,
                                    got.evicted_word, want.evicted_word));
        if (got.miss_total !== want.miss_total)
          report_mismatch($sformatf("beat %0d miss_total %0d, want %0d", beats_out,
                                    got.miss_total, want.miss_total));
        if (got.final_res !== want.final_res)
          report_mismatch($sformatf("beat %0d final_res %b, want %b", beats_out,
                                    got.final_res, want.final_res));
        if (want.hit) hits_seen++;
        if (want.evicted_valid) evictions_seen++;
      end
    endtask

    task report_leftovers();
      if (owed.size() != 0) begin
        report_mismatch($sformatf("%0d results never arrived", owed.size()));
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [WORD_BITS-1:0] word_i;
  logic                 last_word_i;
  logic                 valid_o;
  logic                 hit_o;
  logic                 evicted_valid_o;
  logic [WORD_BITS-1:0] evicted_word_o;
  logic [MISS_W-1:0]    miss_total_o;
  logic                 final_res_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  cache_tracker tracker = new();
  string        caps_used = "64";

  fifo_cache_miss_counter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .word_i          (word_i),
    .last_word_i     (last_word_i),
    .valid_o         (valid_o),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_word_o  (evicted_word_o),
    .miss_total_o    (miss_total_o),
    .final_res_o     (final_res_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", tracker.owed.size());
    $display("Mismatches found");
    $finish;
  end

  // monitor: an accepted beat is predicted before the result check on the same
  // edge, so the oldest expectation is always queued ahead of its result
  always @(posedge clk_i) begin
    lookup_outcome_t got;
    if (rst_ni) begin
      if (start && !busy) begin
        tracker.note_lookup(word_i, last_word_i);
      end
      if (valid_o) begin
        got.hit = hit_o;
        got.evicted_valid = evicted_valid_o;
        got.evicted_word = evicted_word_o;
        got.miss_total = miss_total_o;
        got.final_res = final_res_o;
        tracker.check_outcome(got);
      end
    end
  end

  // drive one lookup beat and hold it until taken; returns at a falling edge
  // with start still high so back-to-back beats need no gap
  task send_lookup(logic [WORD_BITS-1:0] w, logic last);
    start <= 1'b1;
    word_i <= w;
    last_word_i <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // stop sending and wait until every owed result has come back
  task wait_for_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while (tracker.owed.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // apb write: setup cycle then access cycle, register updates at the access edge
  task write_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.set_register(addr, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task set_capacity(logic [CAP_W-1:0] cap);
    wait_for_results();
    write_register(CAPACITY_ADDR, DATA_W'(cap));
    caps_used = {caps_used, $sformatf(" %0d", cap)};
  endtask

  // one stretch of random traffic at a given capacity; most words come from a
  // pool a bit larger than the usable capacity so hits and evictions both show up
  task run_traffic(int unsigned beats, bit mid_drain);
    logic [WORD_BITS-1:0] pool [$];
    logic [WORD_BITS-1:0] w;
    int unsigned          pool_size;
    int unsigned          sent;
    int unsigned          burst;
    int unsigned          gap;
    int unsigned          pick;
    pool_size = tracker.usable_entries() + tracker.usable_entries() / 2 + 1;
    for (int unsigned i = 0; i < pool_size; i++) begin
      pool = {pool, WORD_BITS'($urandom)};
    end
    sent = 0;
    while (sent < beats) begin
      burst = $urandom_range(1, 40);
      // a quarter of the bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int unsigned b = 0; b < burst && sent < beats; b++) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          w = pool[$urandom_range(0, pool.size() - 1)];
        end else if (pick == 7) begin
          w = $urandom_range(0, 1) ? '1 : '0;
        end else begin
          w = WORD_BITS'($urandom);
        end
        send_lookup(w, $urandom_range(0, 15) == 0);
        sent++;
        // hold off once mid-stretch until the block has answered everything
        if (mid_drain && sent == beats / 2) begin
          wait_for_results();
        end
      end
      if (gap > 0) begin
        pause_sender(gap);
      end
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [10];
    rst_ni = 1'b0;
    start = 1'b0;
    word_i = '0;
    last_word_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extreme words, repeats that hit, end-of-sequence marks,
    // at the reset capacity of 64
    send_lookup('0, 1'b0);
    send_lookup('1, 1'b0);
    send_lookup('0, 1'b0);
    send_lookup('1, 1'b1);
    send_lookup(16'h8000, 1'b0);
    send_lookup(16'h0001, 1'b0);
    send_lookup(16'hAAAA, 1'b0);
    send_lookup(16'h5555, 1'b1);

    // capacity dropped below the fill: each miss pushes out just one entry
    set_capacity(CAP_W'(2));
    send_lookup(16'h1234, 1'b0);
    send_lookup(16'h1234, 1'b0);
    send_lookup(16'h4321, 1'b0);
    send_lookup(16'h5555, 1'b0);
    send_lookup(16'h0000, 1'b1);

    // write to an address with no register behind it: must change nothing
    wait_for_results();
    write_register(UNUSED_ADDR, 32'h0000_0001);

    // capacity zero behaves as one
    set_capacity(CAP_W'(0));
    send_lookup(16'hBEEF, 1'b0);
    send_lookup(16'hBEEF, 1'b0);
    send_lookup(16'hCAFE, 1'b0);
    send_lookup(16'hBEEF, 1'b1);

    // capacity above the depth behaves as the depth
    set_capacity('1);
    send_lookup(16'h7FFF, 1'b0);
    send_lookup(16'hFFFE, 1'b0);
    send_lookup(16'h7FFF, 1'b1);

    // random phases over a spread of capacities, extremes included
    phase_caps[0] = '1;
    phase_caps[1] = CAP_W'(65);
    phase_caps[2] = CAP_W'(3);
    phase_caps[3] = CAP_W'(0);
    phase_caps[4] = CAP_W'(1);
    phase_caps[5] = CAP_W'(64);
    phase_caps[6] = CAP_W'(17);
    phase_caps[7] = CAP_W'($urandom_range(1, 64));
    phase_caps[8] = CAP_W'($urandom_range(0, 127));
    phase_caps[9] = CAP_W'(40);
    for (int p = 0; p < 10; p++) begin
      set_capacity(phase_caps[p]);
      run_traffic(133, p == 4);
    end

    wait_for_results();
    tracker.report_leftovers();
    $display("%0d lookups sent, %0d results checked, %0d hits, %0d evictions",
             tracker.beats_in, tracker.beats_out, tracker.hits_seen, tracker.evictions_seen);
    $display("capacities exercised: %s", caps_used);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fcmc_pkg.sv
design/fcmc_cell.sv
design/fifo_cache_miss_counter.sv
design/fcmc_checker.sv
verif/fifo_cache_miss_counter_tb.sv
